// ===== rtl/core/sard_pkg.sv =====
// Shared constants and types for the stable angle run detector.
// No dependencies; every other file of the block refers to this package.
package sard_pkg;

  // Longest sequence that the sample counter tracks before it saturates
  localparam int MAX_SAMPLES = 65536;

  // Field widths
  localparam int ANGLE_W  = 19;
  localparam int FRAMES_W = 16;
  localparam int RUN_W    = 17;
  localparam int D1_W     = ANGLE_W + 1;
  localparam int D2_W     = ANGLE_W + 2;
  localparam int IDX_W    = $clog2(MAX_SAMPLES) + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ANGLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE  = CFG_IDX_W'(1);

  localparam logic [FRAMES_W-1:0] MIN_FRAMES_RST = FRAMES_W'(0);
  localparam logic [ANGLE_W-1:0]  MIN_ANGLE_RST  = ANGLE_W'(66);

  // Classification of one accepted sample, from the difference stage
  typedef struct packed {
    logic accept;
    logic stable;
    logic final_sample;
  } cls_t;

endpackage

// ===== rtl/core/sard_if.sv =====
// Handshake channel interfaces: sample input, run result and register write.
// Depends on sard_pkg for field widths.
interface sard_in_if;
  logic                        valid;
  logic                        ready;
  logic [sard_pkg::ANGLE_W-1:0] angle;
  logic                        final_sample;

  modport source (output valid, output angle, output final_sample, input ready);
  modport sink   (input valid, input angle, input final_sample, output ready);
endinterface

interface sard_out_if;
  logic                      valid;
  logic                      ready;
  logic [sard_pkg::RUN_W-1:0] run_start;
  logic [sard_pkg::RUN_W-1:0] run_end;

  modport source (output valid, output run_start, output run_end, input ready);
  modport sink   (input valid, input run_start, input run_end, output ready);
endinterface

interface sard_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sard_pkg::CFG_IDX_W-1:0]  index;
  logic [sard_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sard_diff.sv =====
// Difference stage: first and second difference of the angle stream and the
// stability compare against the tolerance. Depends on sard_pkg.
module sard_diff (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [sard_pkg::ANGLE_W-1:0] angle,
  input  logic                         final_sample,
  input  logic [sard_pkg::ANGLE_W-1:0] min_angle,
  output sard_pkg::cls_t               cls
);

  logic        [sard_pkg::ANGLE_W-1:0] prev_angle_r;
  logic signed [sard_pkg::D1_W-1:0]    prev_d1_r;
  logic signed [sard_pkg::D1_W-1:0]    d1;
  logic signed [sard_pkg::D2_W-1:0]    d2;
  logic signed [sard_pkg::D2_W-1:0]    tol;
  logic signed [sard_pkg::D2_W-1:0]    neg_tol;

  // Form the differences; both fit their widths exactly
  assign d1      = {1'b0, angle} - {1'b0, prev_angle_r};
  assign d2      = {d1[sard_pkg::D1_W-1], d1} - {prev_d1_r[sard_pkg::D1_W-1], prev_d1_r};
  assign tol     = {2'b00, min_angle};
  assign neg_tol = -tol;

  // Classify the sample
  assign cls.accept       = accept;
  assign cls.stable       = (d2 > neg_tol) && (d2 < tol);
  assign cls.final_sample = final_sample;

  // Hold the history; drop it after the last sample of a sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      prev_d1_r    <= '0;
    end else if (accept) begin
      if (final_sample) begin
        prev_angle_r <= '0;
        prev_d1_r    <= '0;
      end else begin
        prev_angle_r <= angle;
        prev_d1_r    <= d1;
      end
    end
  end

endmodule

// ===== rtl/core/sard_run.sv =====
// Run tracker: sample counter, open-run state, length check and the result
// register that feeds the output channel. Depends on sard_pkg.
module sard_run (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sard_pkg::cls_t                cls,
  input  logic [sard_pkg::FRAMES_W-1:0] min_frames,
  input  logic                          out_ready,
  output logic                          in_ready,
  output logic                          out_valid,
  output logic [sard_pkg::RUN_W-1:0]    run_start,
  output logic [sard_pkg::RUN_W-1:0]    run_end
);

  localparam logic [sard_pkg::IDX_W-1:0] IDX_LAST = sard_pkg::IDX_W'(sard_pkg::MAX_SAMPLES - 1);

  logic [sard_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       in_run_r, in_run_nxt;
  logic [sard_pkg::IDX_W-1:0] start_r, start_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [sard_pkg::RUN_W-1:0] run_start_r, run_end_r;

  logic [sard_pkg::IDX_W-1:0] close_start;
  logic [sard_pkg::IDX_W-1:0] close_end;
  logic [sard_pkg::IDX_W-1:0] run_len;
  logic                       closing;
  logic                       emit;

  // Accept while the result register is free or is being drained
  assign in_ready = !out_valid_r || out_ready;

  // Pick the run that closes with this sample, if any
  always_comb begin
    start_nxt   = (cls.stable && !in_run_r) ? idx_r : start_r;
    close_start = start_nxt;
    close_end   = idx_r + sard_pkg::IDX_W'(1);
    closing     = 1'b0;
    if (!cls.stable && in_run_r) begin
      close_start = start_r;
      close_end   = idx_r;
      closing     = 1'b1;
    end else if (cls.stable && cls.final_sample) begin
      closing     = 1'b1;
    end
    run_len = close_end - close_start;
    emit    = cls.accept && closing &&
              (run_len > sard_pkg::IDX_W'(min_frames));
  end

  // Advance the counter and run state on each transfer
  always_comb begin
    idx_nxt    = idx_r;
    in_run_nxt = in_run_r;
    if (cls.accept) begin
      if (cls.final_sample) begin
        idx_nxt    = '0;
        in_run_nxt = 1'b0;
      end else begin
        in_run_nxt = cls.stable;
        if (idx_r < IDX_LAST) begin
          idx_nxt = idx_r + sard_pkg::IDX_W'(1);
        end
      end
    end
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      in_run_r    <= 1'b0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      in_run_r    <= in_run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cls.accept) begin
        start_r <= cls.final_sample ? '0 : start_nxt;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit) begin
      run_start_r <= sard_pkg::RUN_W'(close_start);
      run_end_r   <= sard_pkg::RUN_W'(close_end);
    end
  end

  assign out_valid = out_valid_r;
  assign run_start = run_start_r;
  assign run_end   = run_end_r;

  // A reported run is never empty
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (run_end_r > run_start_r))
    else $error("reported run has end not after start");

  // Counter saturates below the sequence limit
  a_idx_sat: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("sample counter past its limit");

  // An open run starts no later than the current sample
  a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (start_r <= idx_r))
    else $error("open run starts after current sample");

  // The last sample of a sequence leaves a clean state
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cls.accept && cls.final_sample) |=> (idx_r == '0 && !in_run_r))
    else $error("sequence state not cleared after last sample");

  // A result is only loaded when the register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cls.accept)
    else $error("transfer accepted while result register is stalled");

endmodule

// ===== rtl/core/stable_angle_run_detector.sv =====
// Top level of the stable angle run detector: register file, difference
// stage and run tracker. Depends on sard_pkg, sard_if, sard_diff, sard_run.
//
//   channel   dir  payload                    transfer
//   in_ch     in   angle[18:0], final_sample  valid & ready
//   out_ch    out  run_start[16:0], run_end   valid & ready
//   cfg_ch    in   index[1:0], data[18:0]     valid & ready (ready always high)
//
// One sample per cycle while in_ch.ready is high; a result appears in the result
// register in the cycle after the sample that closes the run, through the single
// register stage between the sample transfer and the output channel.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Reset is synchronous, active low: sequence state cleared, min_frames = 0,
// min_angle = 66.
module stable_angle_run_detector (
  input  logic clk,
  input  logic rst_n,
  sard_in_if.sink    in_ch,
  sard_out_if.source out_ch,
  sard_cfg_if.sink   cfg_ch
);

  logic [sard_pkg::FRAMES_W-1:0] min_frames_r;
  logic [sard_pkg::ANGLE_W-1:0]  min_angle_r;
  logic                          in_ready;
  logic                          in_accept;
  sard_pkg::cls_t                cls;

  assign cfg_ch.ready = 1'b1;

  // Write the configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_frames_r <= sard_pkg::MIN_FRAMES_RST;
      min_angle_r  <= sard_pkg::MIN_ANGLE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sard_pkg::REG_MIN_FRAMES: min_frames_r <= cfg_ch.data[sard_pkg::FRAMES_W-1:0];
        sard_pkg::REG_MIN_ANGLE:  min_angle_r  <= cfg_ch.data[sard_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  sard_diff u_diff (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .angle        (in_ch.angle),
    .final_sample (in_ch.final_sample),
    .min_angle    (min_angle_r),
    .cls          (cls)
  );

  sard_run u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .cls        (cls),
    .min_frames (min_frames_r),
    .out_ready  (out_ch.ready),
    .in_ready   (in_ready),
    .out_valid  (out_ch.valid),
    .run_start  (out_ch.run_start),
    .run_end    (out_ch.run_end)
  );

endmodule
